### rtl/core/g2e_pkg.sv
// ----------------------------------------------------------------------------
// g2e_pkg - shared types and constants for the geodetic to ECEF converter
// Cell payload structs, WGS84 constants in fixed point, CORDIC angle table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package g2e_pkg;

  localparam int CordicSteps = 30;
  localparam int SqrtSteps   = 32;
  localparam int DivSteps    = 34;

  // Q30 unity, CORDIC start gain, e^2 in Q40, semi-major axis in mm
  localparam logic signed [32:0] Q30One     = 33'sd1073741824;
  localparam logic signed [32:0] CordicGain = 33'sd652032874;
  localparam logic [32:0]        E2Q40      = 33'd7360548640;
  localparam logic [32:0]        SemiMajor  = 33'd6378137000;

  // one CORDIC rotator stage
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
  } cordic_t;

  // one square root digit stage
  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [63:0] v;
  } sqrt_t;

  // one restoring divider stage
  typedef struct packed {
    logic [31:0] rem;
    logic [33:0] num;
    logic [33:0] quo;
    logic [31:0] dvsr;
  } div_t;

  // side data riding alongside the root and divide chains
  typedef struct packed {
    logic signed [37:0] h;
    logic signed [31:0] cl;
    logic signed [31:0] sl;
    logic signed [31:0] co;
    logic signed [31:0] so;
  } side_t;

  // atan(2^-i) in binary-angle units
  function automatic logic signed [32:0] atan_lut(input logic [4:0] idx);
    logic signed [32:0] a;
    case (idx)
      5'd0:  a = 33'sd536870912;
      5'd1:  a = 33'sd316933406;
      5'd2:  a = 33'sd167458907;
      5'd3:  a = 33'sd85004756;
      5'd4:  a = 33'sd42667331;
      5'd5:  a = 33'sd21354465;
      5'd6:  a = 33'sd10679838;
      5'd7:  a = 33'sd5340245;
      5'd8:  a = 33'sd2670163;
      5'd9:  a = 33'sd1335087;
      5'd10: a = 33'sd667544;
      5'd11: a = 33'sd333772;
      5'd12: a = 33'sd166886;
      5'd13: a = 33'sd83443;
      5'd14: a = 33'sd41722;
      5'd15: a = 33'sd20861;
      5'd16: a = 33'sd10430;
      5'd17: a = 33'sd5215;
      5'd18: a = 33'sd2608;
      5'd19: a = 33'sd1304;
      5'd20: a = 33'sd652;
      5'd21: a = 33'sd326;
      5'd22: a = 33'sd163;
      5'd23: a = 33'sd81;
      5'd24: a = 33'sd41;
      5'd25: a = 33'sd20;
      5'd26: a = 33'sd10;
      5'd27: a = 33'sd5;
      5'd28: a = 33'sd3;
      5'd29: a = 33'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/core/g2e_cordic_cell.sv
// ----------------------------------------------------------------------------
// g2e_cordic_cell - one rotation-mode CORDIC micro-rotation
// Rotates by +-atan(2^-step) and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module g2e_cordic_cell (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [4:0]         step_i,
  input  g2e_pkg::cordic_t   rot_i,
  output g2e_pkg::cordic_t   rot_o
);
  import g2e_pkg::*;

  cordic_t            rot_d, rot_q;
  logic signed [32:0] dx, dy, da;

  always_comb begin
    dx = $signed(rot_i.y) >>> step_i;
    dy = $signed(rot_i.x) >>> step_i;
    da = atan_lut(step_i);
    if (!rot_i.z[32]) begin
      rot_d.x = rot_i.x - dx;
      rot_d.y = rot_i.y + dy;
      rot_d.z = rot_i.z - da;
    end else begin
      rot_d.x = rot_i.x + dx;
      rot_d.y = rot_i.y - dy;
      rot_d.z = rot_i.z + da;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) rot_q <= rot_d;
  end

  assign rot_o = rot_q;

endmodule

### rtl/core/g2e_sqrt_cell.sv
// ----------------------------------------------------------------------------
// g2e_sqrt_cell - one digit of a restoring integer square root
// Brings down two radicand bits and settles one root bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module g2e_sqrt_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  g2e_pkg::sqrt_t  sq_i,
  output g2e_pkg::sqrt_t  sq_o
);
  import g2e_pkg::*;

  sqrt_t       sq_d, sq_q;
  logic [35:0] rem_t, test;

  always_comb begin
    rem_t = {sq_i.rem, sq_i.v[63:62]};
    test  = {2'b00, sq_i.root, 2'b01};
    sq_d.v = {sq_i.v[61:0], 2'b00};
    if (rem_t >= test) begin
      sq_d.rem  = 34'(rem_t - test);
      sq_d.root = {sq_i.root[30:0], 1'b1};
    end else begin
      sq_d.rem  = rem_t[33:0];
      sq_d.root = {sq_i.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) sq_q <= sq_d;
  end

  assign sq_o = sq_q;

endmodule

### rtl/core/g2e_div_cell.sv
// ----------------------------------------------------------------------------
// g2e_div_cell - one bit of a restoring divider
// Shifts in one dividend bit, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module g2e_div_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  g2e_pkg::div_t  dv_i,
  output g2e_pkg::div_t  dv_o
);
  import g2e_pkg::*;

  div_t        dv_d, dv_q;
  logic [32:0] t;

  always_comb begin
    t         = {dv_i.rem, dv_i.num[33]};
    dv_d.num  = {dv_i.num[32:0], 1'b0};
    dv_d.dvsr = dv_i.dvsr;
    if (t >= {1'b0, dv_i.dvsr}) begin
      dv_d.rem = 32'(t - {1'b0, dv_i.dvsr});
      dv_d.quo = {dv_i.quo[32:0], 1'b1};
    end else begin
      dv_d.rem = t[31:0];
      dv_d.quo = {dv_i.quo[32:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) dv_q <= dv_d;
  end

  assign dv_o = dv_q;

endmodule

### rtl/core/g2e_mulq30.sv
// ----------------------------------------------------------------------------
// g2e_mulq30 - two-stage rounded product with a Q30 factor
// round(v * f / 2^30), half up; v split into two partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module g2e_mulq30 (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [38:0] v_i,
  input  logic signed [31:0] f_i,
  output logic signed [38:0] p_o
);
  import g2e_pkg::*;

  localparam logic signed [71:0] Half = 72'sd536870912;

  logic signed [52:0] plo_d, plo_q;
  logic signed [50:0] phi_d, phi_q;
  logic signed [71:0] sum;
  logic signed [38:0] p_q;

  always_comb begin
    plo_d = $signed({1'b0, v_i[19:0]}) * f_i;
    phi_d = $signed(v_i[38:20]) * f_i;
    sum   = (72'(phi_q) <<< 20) + 72'(plo_q) + Half;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
      p_q   <= sum[68:30];
    end
  end

  assign p_o = p_q;

endmodule

### rtl/core/geodetic_to_ecef_top.sv
// ----------------------------------------------------------------------------
// geodetic_to_ecef_top - WGS84 geodetic to Earth-centred Earth-fixed
// Latitude, longitude, height in; X, Y, Z in millimetres out, saturated.
// ----------------------------------------------------------------------------
//  channel  dir  tdata fields (lsb first)                        width
//  s_axis   in   latitude[31:0] longitude[63:32] height[101:64]  104
//  m_axis   out  pos_x[37:0] pos_y[75:38] pos_z[113:76]          120
//
//  One request per cycle sustained while results are taken; the pipeline holds
//  the 30-cell CORDIC row, the 32-cell root row and the 34-cell divide row.
//  A stalled output freezes the whole pipeline in place; s_axis_tready is
//  low only while a result waits and m_axis_tready is low.
//  Reset clears the valid line only; payload flops carry no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module geodetic_to_ecef_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // latitude, longitude, height, pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata    // pos_x, pos_y, pos_z, pad
);
  import g2e_pkg::*;

  // valid line positions
  localparam int StS1    = CordicSteps + 1;
  localparam int StS4    = StS1 + 3;
  localparam int StSqrt  = StS4 + SqrtSteps;
  localparam int StDiv   = StSqrt + DivSteps;
  localparam int StOut   = StDiv + 6;
  localparam int Depth   = StOut + 1;
  localparam int SideLen = 3 + SqrtSteps + DivSteps;

  localparam logic [63:0] NumBase = {SemiMajor, 31'd0};
  localparam logic [40:0] DOne    = 41'h100_0000_0000;

  typedef struct packed {
    logic signed [37:0] h;
    logic               flip;
  } hf_t;

  function automatic logic signed [31:0] clamp_q30(input logic signed [32:0] v);
    logic signed [32:0] c;
    c = v;
    if (v > Q30One) c = Q30One;
    else if (v < -Q30One) c = -Q30One;
    return c[31:0];
  endfunction

  function automatic logic [37:0] sat38(input logic signed [38:0] v);
    logic [37:0] r;
    if (v[38] != v[37]) r = v[38] ? {1'b1, 37'd0} : {1'b0, {37{1'b1}}};
    else r = v[37:0];
    return r;
  endfunction

  logic             en;
  logic [Depth-1:0] vld_q;

  assign en            = !vld_q[StOut] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[StOut];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  // ---- S0: clamp latitude, fold longitude into +-90 degrees ----
  logic signed [31:0] lat_in, lon_in;
  logic signed [32:0] lat_d, lat_q, lon_d, lon_q;
  logic               flip_d, flip_q;
  logic signed [37:0] h_q;

  always_comb begin
    lat_in = s_axis_tdata[31:0];
    lon_in = s_axis_tdata[63:32];
    lat_d  = 33'(lat_in);
    if (lat_d > Q30One) lat_d = Q30One;
    else if (lat_d < -Q30One) lat_d = -Q30One;
    lon_d  = 33'(lon_in);
    flip_d = 1'b0;
    if (lon_d > Q30One || lon_d < -Q30One) begin
      lon_d  = 33'($signed({~lon_in[31], lon_in[30:0]}));
      flip_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat_q  <= lat_d;
      lon_q  <= lon_d;
      flip_q <= flip_d;
      h_q    <= s_axis_tdata[101:64];
    end
  end

  // ---- CORDIC rows for latitude and longitude ----
  cordic_t lat_c [0:CordicSteps];
  cordic_t lon_c [0:CordicSteps];
  hf_t     hl_q  [0:CordicSteps-1];

  assign lat_c[0] = '{x: CordicGain, y: '0, z: lat_q};
  assign lon_c[0] = '{x: CordicGain, y: '0, z: lon_q};

  for (genvar k = 0; k < CordicSteps; k++) begin : g_cordic
    g2e_cordic_cell u_lat (
      .clk_i (clk_i), .en_i (en), .step_i (5'(k)),
      .rot_i (lat_c[k]), .rot_o (lat_c[k+1])
    );
    g2e_cordic_cell u_lon (
      .clk_i (clk_i), .en_i (en), .step_i (5'(k)),
      .rot_i (lon_c[k]), .rot_o (lon_c[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hl_q[0] <= '{h: h_q, flip: flip_q};
      for (int i = 1; i < CordicSteps; i++) hl_q[i] <= hl_q[i-1];
    end
  end

  // ---- S1..S4: clamp, sin^2, e2 product, radicand ----
  side_t              s1_q;
  side_t              sd_q [0:SideLen-1];
  logic signed [63:0] sq_prod;
  logic        [30:0] s2_q;
  logic        [47:0] pa_q;
  logic        [48:0] pb_q;
  logic        [63:0] e2s2;
  logic        [40:0] d_q;

  always_comb begin
    sq_prod = s1_q.sl * s1_q.sl;
    e2s2    = {pa_q, 16'd0} + 64'(pb_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.h  <= hl_q[CordicSteps-1].h;
      s1_q.cl <= clamp_q30(lat_c[CordicSteps].x);
      s1_q.sl <= clamp_q30(lat_c[CordicSteps].y);
      s1_q.co <= hl_q[CordicSteps-1].flip ? -clamp_q30(lon_c[CordicSteps].x)
                                          :  clamp_q30(lon_c[CordicSteps].x);
      s1_q.so <= hl_q[CordicSteps-1].flip ? -clamp_q30(lon_c[CordicSteps].y)
                                          :  clamp_q30(lon_c[CordicSteps].y);
      s2_q    <= sq_prod[60:30];
      pa_q    <= E2Q40 * s2_q[30:16];
      pb_q    <= E2Q40 * s2_q[15:0];
      d_q     <= DOne - 41'(e2s2[63:30]);
      sd_q[0] <= s1_q;
      for (int i = 1; i < SideLen; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  // ---- square root row: r = floor(sqrt(d * 2^22)) ----
  sqrt_t sq [0:SqrtSteps];

  assign sq[0] = '{rem: '0, root: '0, v: {1'b0, d_q, 22'd0}};

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    g2e_sqrt_cell u_cell (
      .clk_i (clk_i), .en_i (en), .sq_i (sq[k]), .sq_o (sq[k+1])
    );
  end

  // ---- divide row: N = round(a * 2^31 / r) ----
  div_t        dv [0:DivSteps];
  logic [31:0] r_g;
  logic [63:0] num;

  always_comb begin
    r_g = (sq[SqrtSteps].root == '0) ? 32'd1 : sq[SqrtSteps].root;
    num = NumBase + 64'(r_g[31:1]);
  end

  assign dv[0] = '{rem: 32'(num[63:34]), num: num[33:0], quo: '0, dvsr: r_g};

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    g2e_div_cell u_cell (
      .clk_i (clk_i), .en_i (en), .dv_i (dv[k]), .dv_o (dv[k+1])
    );
  end

  // ---- S6..S8: N + h, e2 * N, Z lever ----
  side_t              s6_q;
  logic        [33:0] n6_q, n7_q;
  logic signed [38:0] nh6_q, zv8_q, t8;
  logic        [49:0] pea_q, peb_q;
  logic        [67:0] ne2_sum;
  logic        [27:0] ne2_q;
  logic signed [37:0] h7_q;
  logic signed [31:0] sl7_q, co7_q, so7_q, sl8_q, co8_q, so8_q;

  assign ne2_sum = {pea_q, 17'd0} + 68'(peb_q) + {28'd1, 39'd0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_q  <= sd_q[SideLen-1];
      n6_q  <= dv[DivSteps].quo;
      nh6_q <= $signed({5'd0, dv[DivSteps].quo}) + 39'(sd_q[SideLen-1].h);
      pea_q <= E2Q40 * dv[DivSteps].quo[33:17];
      peb_q <= E2Q40 * dv[DivSteps].quo[16:0];
      n7_q  <= n6_q;
      h7_q  <= s6_q.h;
      sl7_q <= s6_q.sl;
      co7_q <= s6_q.co;
      so7_q <= s6_q.so;
      ne2_q <= ne2_sum[67:40];
      zv8_q <= $signed({5'd0, n7_q}) + 39'(h7_q) - $signed({11'd0, ne2_q});
      sl8_q <= sl7_q;
      co8_q <= co7_q;
      so8_q <= so7_q;
    end
  end

  // ---- S7..S10: rounded Q30 products ----
  logic signed [38:0] px, py, pz;

  g2e_mulq30 u_mul_t (
    .clk_i (clk_i), .en_i (en), .v_i (nh6_q), .f_i (s6_q.cl), .p_o (t8)
  );
  g2e_mulq30 u_mul_x (
    .clk_i (clk_i), .en_i (en), .v_i (t8), .f_i (co8_q), .p_o (px)
  );
  g2e_mulq30 u_mul_y (
    .clk_i (clk_i), .en_i (en), .v_i (t8), .f_i (so8_q), .p_o (py)
  );
  g2e_mulq30 u_mul_z (
    .clk_i (clk_i), .en_i (en), .v_i (zv8_q), .f_i (sl8_q), .p_o (pz)
  );

  // ---- output register with saturation ----
  logic [37:0] x_q, y_q, z_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= sat38(px);
      y_q <= sat38(py);
      z_q <= sat38(pz);
    end
  end

  assign m_axis_tdata = {6'd0, z_q, y_q, x_q};

  // ---- checks ----
  a_lon_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (lon_q <= Q30One && lon_q >= -Q30One))
    else $error("longitude fold out of range");

  a_d_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StS4] |-> (d_q <= DOne && d_q >= DOne - 41'(E2Q40)))
    else $error("1 - e2 sin^2 out of range");

  a_root_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StSqrt] |-> (sq[SqrtSteps].root[31] || sq[SqrtSteps].root[30]))
    else $error("root below 0.5");

  a_radius_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StDiv] |-> !dv[DivSteps].quo[33])
    else $error("prime-vertical radius overflow");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule

### tb/sv/geodetic_to_ecef_checker.sv
// ----------------------------------------------------------------------------
// geodetic_to_ecef_checker - scoreboard for the geodetic to ECEF converter
// Watches both stream channels, predicts X, Y, Z for every accepted request
// in fixed point and compares each result, in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module geodetic_to_ecef_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // latitude, longitude, height, pad
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [119:0] m_axis_tdata,   // pos_x, pos_y, pos_z, pad
  output int           fail_count_o,
  output int           pending_o
);
  import g2e_pkg::*;

  typedef struct {
    logic signed [37:0] x;
    logic signed [37:0] y;
    logic signed [37:0] z;
  } ecef_t;

  ecef_t ecef_q[$];
  int    fails;
  int    pending;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  // rotation-mode CORDIC, Q30 outputs clamped to +-1
  function automatic void rotate(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    x = CordicGain;
    y = 0;
    z = ang;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_lut(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_lut(i[4:0]));
      end
    end
    c = (x > 64'sd1073741824) ? 64'sd1073741824 : ((x < -64'sd1073741824) ? -64'sd1073741824 : x);
    s = (y > 64'sd1073741824) ? 64'sd1073741824 : ((y < -64'sd1073741824) ? -64'sd1073741824 : y);
  endfunction

  // v * f / 2^30 rounded half up
  function automatic longint scale_q30(input longint v, input longint f);
    longint hi, lo;
    hi = v >>> 30;
    lo = v - hi * 64'sd1073741824;
    return hi * f + ((lo * f + 64'sd536870912) >>> 30);
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v  -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [37:0] saturate(input longint v);
    if (v > 64'sd137438953471) return 38'sh1FFFFFFFFF;
    if (v < -64'sd137438953472) return 38'sh2000000000;
    return v[37:0];
  endfunction

  function automatic ecef_t convert(input logic [103:0] req);
    ecef_t res;
    longint lat, lon, h, cl, sl, co, so, t;
    longint unsigned s2, d, r, n, ne2, e2, phi, plo;
    e2  = E2Q40;
    lat = longint'($signed(req[31:0]));
    if (lat > 64'sd1073741824) lat = 64'sd1073741824;
    if (lat < -64'sd1073741824) lat = -64'sd1073741824;
    lon = longint'($signed(req[63:32]));
    h   = longint'($signed(req[101:64]));
    rotate(lat, cl, sl);
    if (lon > 64'sd1073741824 || lon < -64'sd1073741824) begin
      // fold into the right half-plane, then flip both components
      lon = longint'($signed(req[63:32] ^ 32'h80000000));
      rotate(lon, co, so);
      co = -co;
      so = -so;
    end else begin
      rotate(lon, co, so);
    end
    s2 = longint'(sl * sl) >> 30;
    d  = (64'd1 << 40) - ((e2 * s2) >> 30);
    r  = root_floor(d << 22);
    if (r == 0) r = 1;
    n   = ((longint'(SemiMajor) << 31) + (r >> 1)) / r;
    phi = (n >> 20) * e2;
    plo = (n & 64'hFFFFF) * e2;
    ne2 = (phi >> 20) + ((((phi & 64'hFFFFF) << 20) + plo + (64'd1 << 39)) >> 40);
    t     = scale_q30(longint'(n) + h, cl);
    res.x = saturate(scale_q30(t, co));
    res.y = saturate(scale_q30(t, so));
    res.z = saturate(scale_q30(longint'(n) - longint'(ne2) + h, sl));
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [37:0] got,
                                 input logic [37:0] want);
    $display("%0t: mismatch %s got %0d expected %0d", $realtime, what,
             $signed(got), $signed(want));
    fails++;
  endtask

  initial begin
    fails   = 0;
    pending = 0;
  end

  always @(posedge clk_i) begin
    ecef_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) ecef_q.push_back(convert(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (ecef_q.size() == 0) begin
          $display("%0t: result with no request outstanding", $realtime);
          fails++;
        end else begin
          want = ecef_q.pop_front();
          if (m_axis_tdata[37:0] !== want.x)
            report_mismatch("pos_x", m_axis_tdata[37:0], want.x);
          if (m_axis_tdata[75:38] !== want.y)
            report_mismatch("pos_y", m_axis_tdata[75:38], want.y);
          if (m_axis_tdata[113:76] !== want.z)
            report_mismatch("pos_z", m_axis_tdata[113:76], want.z);
        end
      end
      pending = ecef_q.size();
    end
  end

endmodule

### tb/sv/geodetic_to_ecef_top_tb.sv
// ----------------------------------------------------------------------------
// geodetic_to_ecef_top_tb - testbench top for the geodetic to ECEF converter
// Directed corner requests then random ones, bursty sender, stalling
// receiver; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module geodetic_to_ecef_top_tb;

  localparam int RandomReqs = 630;
  localparam int Latency    = 107;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;   // latitude, longitude, height, pad
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [119:0] m_axis_tdata;   // pos_x, pos_y, pos_z, pad
  int           fail_count;
  int           pending;

  // receiver state: stall pattern and one long hold-off
  int           rx_cycle = 0;
  int           rx_mode  = 0;

  geodetic_to_ecef_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  geodetic_to_ecef_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard limit, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: mode changes every so often (always ready, light stalls,
  // heavy stalls); one long hold-off, while the random requests are still
  // coming, fills the pipe.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 200 == 0) rx_mode <= $urandom_range(2);
    if (rx_cycle >= 400 && rx_cycle < 800) begin
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(3) != 0);
        default: m_axis_tready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  // sender burst state
  int burst_left;

  // offer one request and hold it until taken; a gap only between bursts
  task automatic send_request(input logic [31:0] lat, input logic [31:0] lon,
                              input logic [37:0] h);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b0, h, lon, lat};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // lower valid and wait until every prediction has been matched
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    burst_left = 0;
  endtask

  function automatic logic [37:0] rand_height();
    case ($urandom_range(3))
      0:       return 38'({$urandom, $urandom}); // any 38-bit pattern
      1:       return 38'($signed($urandom_range(20000000)) - 10000000);
      default: return 38'($urandom_range(1000000000)) * 38'd100;
    endcase
  endfunction

  initial begin
    logic [31:0] lat;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    burst_left    = 0;
    rst_ni        = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: equator, poles, latitude past a pole, longitude fold edges,
    // height extremes and output saturation
    send_request(32'd0,          32'd0,          38'd0);
    send_request(32'h40000000,   32'd0,          38'd0);
    send_request(32'hC0000000,   32'h40000000,   38'd0);
    send_request(32'h40000001,   32'd12345,      38'd1000);
    send_request(32'h7FFFFFFF,   32'h80000000,   38'd0);
    send_request(32'h80000000,   32'h7FFFFFFF,   38'd0);
    send_request(32'hBFFFFFFF,   32'hBFFFFFFF,   38'd5);
    send_request(32'd0,          32'h40000001,   38'd0);
    send_request(32'd0,          32'hC0000000,   38'd0);
    send_request(32'd0,          32'h80000000,   38'h1FFFFFFFFF);
    send_request(32'd0,          32'd0,          38'h1FFFFFFFFF);
    send_request(32'd0,          32'd0,          38'h2000000000);
    send_request(32'h40000000,   32'd0,          38'h1FFFFFFFFF);
    send_request(32'hC0000000,   32'd0,          38'h2000000000);
    send_request(32'h20000000,   32'h20000000,   38'd100000000000);
    send_request(32'hE0000000,   32'hA0000000,   -38'sd100000000);
    send_request(32'hFFFFFFFF,   32'hFFFFFFFF,   38'h3FFFFFFFFF);
    send_request(32'h00000001,   32'h00000001,   38'd1);
    send_request(32'h15555555,   32'h55555555,   38'h2AAAAAAAAA);
    send_request(32'hEAAAAAAA,   32'hAAAAAAAA,   38'h1555555555);
    drain();

    for (int i = 0; i < RandomReqs; i++) begin
      // mostly valid latitudes, some anywhere in the word to hit the clamp
      lat = ($urandom_range(4) == 0) ? $urandom
                                     : 32'($signed($urandom_range(32'h80000000)) - 32'sh40000000);
      send_request(lat, $urandom, rand_height());
      if (i == RandomReqs / 2) drain();
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/g2e_pkg.sv
rtl/core/g2e_cordic_cell.sv
rtl/core/g2e_sqrt_cell.sv
rtl/core/g2e_div_cell.sv
rtl/core/g2e_mulq30.sv
rtl/core/geodetic_to_ecef_top.sv
tb/sv/geodetic_to_ecef_checker.sv
tb/sv/geodetic_to_ecef_top_tb.sv
